[design/aes128_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_pkg
// Shared types, S-box, round constants and round helper functions.
// ----------------------------------------------------------------------------
package aes128_pkg;

    typedef logic [127:0] blk_t;
    typedef logic [7:0]   byte_t;

    localparam int NumRounds = 10;

    // forward S-box
    function automatic byte_t sbox(input byte_t a);
        byte_t r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    // round constant for round index 0..9
    function automatic byte_t rcon(input logic [3:0] rnd);
        byte_t r;
        case (rnd)
            4'd0: r = 8'h01;
            4'd1: r = 8'h02;
            4'd2: r = 8'h04;
            4'd3: r = 8'h08;
            4'd4: r = 8'h10;
            4'd5: r = 8'h20;
            4'd6: r = 8'h40;
            4'd7: r = 8'h80;
            4'd8: r = 8'h1b;
            4'd9: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // byte n of a block, byte 0 in the top bits
    function automatic byte_t get_byte(input blk_t b, input int n);
        return b[127-8*n -: 8];
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // subbytes and shiftrows
    function automatic blk_t sub_shift(input blk_t s);
        blk_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
            end
        end
        return t;
    endfunction

    function automatic blk_t mix_cols(input blk_t s);
        blk_t  t;
        byte_t a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // next round key
    function automatic blk_t expand_next(input blk_t k, input logic [3:0] rnd);
        logic [31:0] g;
        logic [31:0] w0, w1, w2, w3;
        g  = {sbox(get_byte(k, 13)) ^ rcon(rnd), sbox(get_byte(k, 14)),
              sbox(get_byte(k, 15)), sbox(get_byte(k, 12))};
        w0 = k[127:96] ^ g;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[design/aes128_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_round
// One registered cipher round with its own key expansion step.
// ----------------------------------------------------------------------------
module aes128_round
    import aes128_pkg::*;
#(
    parameter logic [3:0] RoundIdx = 4'd0,
    parameter bit         LastRound = 1'b0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  blk_t in_state,
    input  blk_t in_key,
    output logic out_valid,
    output blk_t out_state,
    output blk_t out_key
);

    logic valid_reg;
    blk_t state_reg, key_reg;
    blk_t key_next, state_next, sb;

    // round function
    always_comb begin
        key_next = expand_next(in_key, RoundIdx);
        sb       = sub_shift(in_state);
        if (LastRound) begin
            state_next = sb ^ key_next;
        end else begin
            state_next = mix_cols(sb) ^ key_next;
        end
    end

    // valid travels with the item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule

[design/aes128_block_encrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// AES-128 encryption, one fully unrolled round per pipeline stage.
//
//   channel   dir  ports
//   s_        in   s_valid s_ready s_plaintext_hi/lo s_key_hi/lo
//   m_        out  m_valid m_ready m_cipher_hi/lo
//
// one pipeline stage for the initial key add and one per round
// one item per cycle sustained; the whole pipe advances when its last
// stage is empty or being taken
// a stall holds every stage in place; reset clears all valid bits
// ----------------------------------------------------------------------------
module aes128_block_encrypt
    import aes128_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_plaintext_hi,
    input  logic [63:0] s_plaintext_lo,
    input  logic [63:0] s_key_hi,
    input  logic [63:0] s_key_lo,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_cipher_hi,
    output logic [63:0] m_cipher_lo
);

    logic en;
    logic v0_reg;
    blk_t s0_reg, k0_reg;
    logic [NumRounds:0] vld;
    blk_t st [0:NumRounds];
    blk_t ky [0:NumRounds];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // initial key add stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg <= {s_plaintext_hi, s_plaintext_lo} ^ {s_key_hi, s_key_lo};
            k0_reg <= {s_key_hi, s_key_lo};
        end
    end

    assign vld[0] = v0_reg;
    assign st[0]  = s0_reg;
    assign ky[0]  = k0_reg;

    // round stages
    for (genvar i = 0; i < NumRounds; i++) begin : g_rnd
        aes128_round #(
            .RoundIdx (4'(i)),
            .LastRound(i == NumRounds - 1)
        ) u_round (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (vld[i]),
            .in_state (st[i]),
            .in_key   (ky[i]),
            .out_valid(vld[i+1]),
            .out_state(st[i+1]),
            .out_key  (ky[i+1])
        );
    end

    assign m_valid     = vld[NumRounds];
    assign m_cipher_hi = st[NumRounds][127:64];
    assign m_cipher_lo = st[NumRounds][63:0];

`ifndef SYNTHESIS
    // a stalled result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cipher_hi) && $stable(m_cipher_lo))
        else $error("result changed under stall");

    // an accepted item reaches the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v0_reg)
        else $error("accepted item lost");

    // the pipe is frozen while the output stalls
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld))
        else $error("pipe moved during stall");
`endif

endmodule
